FILE: sv/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CELL_W     = 16;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int COLOR_W    = 4;
    localparam int CFG_IDX_W  = 1;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [CELL_W-1:0]  cell_t;
    typedef logic [COL_W-1:0]   col_t;
    typedef logic [ROW_W-1:0]   row_t;
    typedef logic [COLOR_W-1:0] color_t;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR = 1'b1;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;

    localparam color_t TEXT_COLOR_RESET = 4'd15;
    localparam color_t BACK_COLOR_RESET = 4'd0;

    localparam addr_t LAST_CELL     = addr_t'(CELL_COUNT - 1);
    localparam addr_t COPY_FIRST    = addr_t'(COLUMNS);
    localparam addr_t LAST_ROW_BASE = addr_t'((ROWS - 1) * COLUMNS);
    localparam col_t  COL_LIMIT     = col_t'(COLUMNS);
    localparam row_t  LAST_ROW      = row_t'(ROWS - 1);

    typedef struct packed {
        logic  we;
        addr_t waddr;
        cell_t wdata;
        logic  re;
        addr_t raddr;
    } mem_req_t;

    typedef struct packed {
        logic load;
        logic hit;
        col_t col;
        row_t row;
    } result_t;

    function automatic cell_t make_cell(input logic [7:0] ch, input logic [7:0] attr);
        return {attr, ch};
    endfunction

endpackage

`default_nettype wire

FILE: sv/tcw_ram.sv
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/tcw_ctrl.sv
`default_nettype none

module tcw_ctrl (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [1:0]                          opcode,
    input  wire logic [7:0]                          char_code,
    input  wire tcw_pkg::color_t                     clear_color,
    input  wire tcw_pkg::addr_t                      cell_index,
    input  wire logic                                cfg_we,
    input  wire logic [tcw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire tcw_pkg::color_t                     cfg_data,
    input  wire logic                                out_free,
    input  wire tcw_pkg::cell_t                      rdata,
    output tcw_pkg::mem_req_t                        mem_req,
    output tcw_pkg::result_t                         res
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WRITE = 6'b000010,
        S_COPY  = 6'b000100,
        S_DRAIN = 6'b001000,
        S_FILL  = 6'b010000,
        S_POST  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    tcw_pkg::col_t     col_reg, col_next;
    tcw_pkg::row_t     line_reg, line_next;
    tcw_pkg::color_t   text_color_reg, back_color_reg;
    logic [7:0]        ch_reg, ch_next;
    logic              hit_reg, hit_next;
    logic              pend_reg, pend_next;
    logic              init_reg, init_next;
    tcw_pkg::addr_t    ptr_reg, ptr_next;
    tcw_pkg::cell_t    fill_data_reg, fill_data_next;
    logic              cp_vld_reg, cp_vld_next;
    tcw_pkg::addr_t    cp_waddr_reg, cp_waddr_next;
    logic [7:0]        cur_attr;
    tcw_pkg::addr_t    cursor_addr;

    assign cur_attr    = {back_color_reg, text_color_reg};
    assign cursor_addr = tcw_pkg::addr_t'(
                             tcw_pkg::addr_t'(line_reg) * tcw_pkg::addr_t'(tcw_pkg::COLUMNS)
                             + tcw_pkg::addr_t'(col_reg));

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        line_next      = line_reg;
        ch_next        = ch_reg;
        hit_next       = hit_reg;
        pend_next      = pend_reg;
        init_next      = init_reg;
        ptr_next       = ptr_reg;
        fill_data_next = fill_data_reg;
        cp_vld_next    = 1'b0;
        cp_waddr_next  = tcw_pkg::addr_t'(ptr_reg - tcw_pkg::COPY_FIRST);
        in_ready       = 1'b0;
        res            = '{load: 1'b0, hit: hit_reg, col: col_reg, row: line_reg};

        mem_req.we    = cp_vld_reg;
        mem_req.waddr = cp_waddr_reg;
        mem_req.wdata = rdata;
        mem_req.re    = 1'b0;
        mem_req.raddr = ptr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    hit_next = 1'b0;
                    unique case (opcode)
                        tcw_pkg::OP_PUT:
                        begin
                            ch_next = char_code;
                            if (char_code == tcw_pkg::NEWLINE_CODE)
                            begin
                                col_next = '0;
                                if (line_reg < tcw_pkg::LAST_ROW)
                                begin
                                    line_next  = line_reg + 1'b1;
                                    state_next = S_POST;
                                end
                                else
                                begin
                                    ptr_next   = tcw_pkg::COPY_FIRST;
                                    pend_next  = 1'b0;
                                    state_next = S_COPY;
                                end
                            end
                            else if (col_reg >= tcw_pkg::COL_LIMIT)
                            begin
                                col_next = '0;
                                if (line_reg < tcw_pkg::LAST_ROW)
                                begin
                                    line_next  = line_reg + 1'b1;
                                    state_next = S_WRITE;
                                end
                                else
                                begin
                                    ptr_next   = tcw_pkg::COPY_FIRST;
                                    pend_next  = 1'b1;
                                    state_next = S_COPY;
                                end
                            end
                            else
                            begin
                                state_next = S_WRITE;
                            end
                        end
                        tcw_pkg::OP_CLEAR:
                        begin
                            ptr_next       = '0;
                            pend_next      = 1'b0;
                            fill_data_next = tcw_pkg::make_cell(tcw_pkg::SPACE_CODE,
                                                                {clear_color, clear_color});
                            state_next     = S_FILL;
                        end
                        tcw_pkg::OP_READ:
                        begin
                            hit_next      = (cell_index <= tcw_pkg::LAST_CELL);
                            mem_req.re    = (cell_index <= tcw_pkg::LAST_CELL);
                            mem_req.raddr = cell_index;
                            state_next    = S_POST;
                        end
                        default:
                        begin
                            state_next = S_POST;
                        end
                    endcase
                end
            end
            S_WRITE:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cursor_addr;
                mem_req.wdata = tcw_pkg::make_cell(ch_reg, cur_attr);
                col_next      = col_reg + 1'b1;
                state_next    = S_POST;
            end
            S_COPY:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = ptr_reg;
                cp_vld_next   = 1'b1;
                ptr_next      = ptr_reg + 1'b1;
                if (ptr_reg == tcw_pkg::LAST_CELL)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                ptr_next       = tcw_pkg::LAST_ROW_BASE;
                fill_data_next = tcw_pkg::make_cell(tcw_pkg::SPACE_CODE, cur_attr);
                state_next     = S_FILL;
            end
            S_FILL:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ptr_reg;
                mem_req.wdata = fill_data_reg;
                ptr_next      = ptr_reg + 1'b1;
                if (ptr_reg == tcw_pkg::LAST_CELL)
                begin
                    if (init_reg)
                    begin
                        init_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else if (pend_reg)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_POST;
                    end
                end
            end
            S_POST:
            begin
                res.load = out_free;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_FILL;
            col_reg        <= '0;
            line_reg       <= '0;
            text_color_reg <= tcw_pkg::TEXT_COLOR_RESET;
            back_color_reg <= tcw_pkg::BACK_COLOR_RESET;
            pend_reg       <= 1'b0;
            init_reg       <= 1'b1;
            ptr_reg        <= '0;
            fill_data_reg  <= '0;
            cp_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            line_reg      <= line_next;
            pend_reg      <= pend_next;
            init_reg      <= init_next;
            ptr_reg       <= ptr_next;
            fill_data_reg <= fill_data_next;
            cp_vld_reg    <= cp_vld_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tcw_pkg::REG_TEXT_COLOR: text_color_reg <= cfg_data;
                    tcw_pkg::REG_BACK_COLOR: back_color_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg       <= ch_next;
        hit_reg      <= hit_next;
        cp_waddr_reg <= cp_waddr_next;
    end

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !mem_req.we)
        else $error("screen write while idle");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg <= tcw_pkg::LAST_ROW)
        else $error("cursor row out of range");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= tcw_pkg::COL_LIMIT)
        else $error("cursor column out of range");

    a_copy_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COPY && ptr_reg == tcw_pkg::LAST_CELL)
        |=> (state_reg == S_DRAIN && cp_vld_reg))
        else $error("scroll copy did not drain");

    a_copy_dest: assert property (@(posedge clk) disable iff (!rst_n)
        cp_vld_reg |-> cp_waddr_reg < tcw_pkg::LAST_ROW_BASE)
        else $error("scroll copy writes into the last row");

endmodule

`default_nettype wire

FILE: sv/text_console_writer_core.sv
// Text console engine: a screen of 80 x 25 character/attribute cells in one
// single-port-write RAM, plus a cursor. Opcode 0 puts a character (10 is a
// newline), 1 clears the screen to a space with the clear color in both
// nibbles, 2 reads one cell; every beat returns one result beat with the
// cursor after the operation. Cells are written one per cycle through the
// RAM write port, so that port sets the cost: a plain character writes one
// cell, a newline or read writes none, a clear writes all 2000 cells, and a
// scroll copies 1920 cells, passes a drain state and fills 80 blank cells;
// a printable put that scrolls then writes its character. in_ready stays low
// meanwhile, and the next input beat can be taken in the cycle after the
// result beat is registered. After reset the block sweeps all 2000 cells to
// zero before taking input beats; color register writes are taken at any
// time.
`default_nettype none

module text_console_writer_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      opcode,
    input  wire logic [7:0]                      char_code,
    input  wire logic [3:0]                      clear_color,
    input  wire logic [10:0]                     cell_index,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [7:0]                           read_char,
    output logic [7:0]                           read_attr,
    output logic [6:0]                           cursor_col,
    output logic [4:0]                           cursor_row,
    input  wire logic                            cfg_we,
    input  wire logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [3:0]                      cfg_data
);

    tcw_pkg::mem_req_t mem_req;
    tcw_pkg::result_t  res;
    tcw_pkg::cell_t    rdata;
    logic              out_valid_reg;
    logic              out_free;
    logic [7:0]        read_char_reg, read_attr_reg;
    tcw_pkg::col_t     cursor_col_reg;
    tcw_pkg::row_t     cursor_row_reg;

    assign out_free = !out_valid_reg || out_ready;

    tcw_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .char_code   (char_code),
        .clear_color (clear_color),
        .cell_index  (cell_index),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_free    (out_free),
        .rdata       (rdata),
        .mem_req     (mem_req),
        .res         (res)
    );

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (tcw_pkg::CELL_COUNT)
    ) u_screen (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (rdata)
    );

    // result beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            read_char_reg  <= res.hit ? rdata[7:0]  : 8'd0;
            read_attr_reg  <= res.hit ? rdata[15:8] : 8'd0;
            cursor_col_reg <= res.col;
            cursor_row_reg <= res.row;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_char  = read_char_reg;
    assign read_attr  = read_attr_reg;
    assign cursor_col = cursor_col_reg;
    assign cursor_row = cursor_row_reg;

endmodule

`default_nettype wire

FILE: test/text_console_writer_core_tb.sv
`timescale 1ns / 1ps

module text_console_writer_core_tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int TAIL_CYCLES = 2100;
    localparam int TRAFFIC_PHASES = 8;
    localparam int PHASE_ITEMS = 225;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [7:0]    ch;
        logic [7:0]    attr;
        tcw_pkg::col_t col;
        tcw_pkg::row_t row;
    } console_status_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [1:0] opcode = tcw_pkg::OP_PUT;
    logic [7:0] char_code = '0;
    logic [3:0] clear_color = '0;
    logic [10:0] cell_index = '0;
    logic out_ready = 1'b0;
    logic cfg_we = 1'b0;
    logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index = tcw_pkg::REG_TEXT_COLOR;
    logic [3:0] cfg_data = '0;

    wire logic in_ready;
    wire logic out_valid;
    wire logic [7:0] read_char;
    wire logic [7:0] read_attr;
    wire logic [6:0] cursor_col;
    wire logic [4:0] cursor_row;

    // shadow of the screen, cursor and color registers
    tcw_pkg::cell_t screen_copy [tcw_pkg::CELL_COUNT];
    int cur_col;
    int cur_row;
    tcw_pkg::color_t fg_color;
    tcw_pkg::color_t bg_color;

    console_status_t expected_status [$];

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int err_count = 0;
    int cycle_count = 0;
    int put_count = 0;
    int wrap_count = 0;
    int scroll_count = 0;
    int clear_count = 0;
    int read_count = 0;
    int far_read_count = 0;

    text_console_writer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .char_code   (char_code),
        .clear_color (clear_color),
        .cell_index  (cell_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_char   (read_char),
        .read_attr   (read_attr),
        .cursor_col  (cursor_col),
        .cursor_row  (cursor_row),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_status.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    always @(posedge clk)
    begin
        console_status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_status.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat: char %0d attr %0d col %0d row %0d",
                                          read_char, read_attr, cursor_col, cursor_row));
            end
            else
            begin
                want = expected_status.pop_front();
                check_field("read_char", read_char, want.ch);
                check_field("read_attr", read_attr, want.attr);
                check_field("cursor_col", cursor_col, want.col);
                check_field("cursor_row", cursor_row, want.row);
            end
        end
    end

    function automatic void start_new_line();
        cur_col = 0;
        if (cur_row < tcw_pkg::ROWS - 1)
        begin
            cur_row++;
        end
        else
        begin
            for (int i = 0; i < tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS; i++)
                screen_copy[i] = screen_copy[i + tcw_pkg::COLUMNS];
            for (int c = 0; c < tcw_pkg::COLUMNS; c++)
                screen_copy[(tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS + c] =
                    {bg_color, fg_color, tcw_pkg::SPACE_CODE};
            scroll_count++;
        end
    endfunction

    function automatic console_status_t apply_console_op(input logic [1:0] op,
                                                         input logic [7:0] ch,
                                                         input logic [3:0] cc,
                                                         input logic [10:0] idx);
        console_status_t st;
        st = '0;
        case (op)
            tcw_pkg::OP_PUT:
            begin
                put_count++;
                if (ch == tcw_pkg::NEWLINE_CODE)
                begin
                    start_new_line();
                end
                else
                begin
                    // cursor parked past the right edge wraps first
                    if (cur_col >= tcw_pkg::COLUMNS)
                    begin
                        wrap_count++;
                        start_new_line();
                    end
                    screen_copy[cur_row * tcw_pkg::COLUMNS + cur_col] = {bg_color, fg_color, ch};
                    cur_col++;
                end
            end
            tcw_pkg::OP_CLEAR:
            begin
                clear_count++;
                for (int i = 0; i < tcw_pkg::CELL_COUNT; i++)
                    screen_copy[i] = {cc, cc, tcw_pkg::SPACE_CODE};
            end
            tcw_pkg::OP_READ:
            begin
                read_count++;
                if (int'(idx) < tcw_pkg::CELL_COUNT)
                begin
                    st.ch = screen_copy[idx][7:0];
                    st.attr = screen_copy[idx][15:8];
                end
                else
                begin
                    far_read_count++;
                end
            end
            default:
            begin
            end
        endcase
        st.col = tcw_pkg::col_t'(cur_col);
        st.row = tcw_pkg::row_t'(cur_row);
        return st;
    endfunction

    // called at a rising edge; returns at the edge where the beat is taken
    task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
                             input logic [3:0] cc, input logic [10:0] idx);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        char_code <= ch;
        clear_color <= cc;
        cell_index <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_status.push_back(apply_console_op(op, ch, cc, idx));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_status.size() != 0 || !in_ready)
            @(posedge clk);
    endtask

    task automatic write_colors(input tcw_pkg::color_t fg, input tcw_pkg::color_t bg);
        cfg_we <= 1'b1;
        cfg_index <= tcw_pkg::REG_TEXT_COLOR;
        cfg_data <= fg;
        @(posedge clk);
        fg_color = fg;
        cfg_index <= tcw_pkg::REG_BACK_COLOR;
        cfg_data <= bg;
        @(posedge clk);
        bg_color = bg;
        cfg_we <= 1'b0;
    endtask

    task automatic test_directed_cases();
        // untouched screen reads back zero, out-of-range reads give zero
        send_item(tcw_pkg::OP_READ, 8'hFF, 4'hF, 11'd0);
        send_item(tcw_pkg::OP_READ, 8'h00, 4'h0, 11'(tcw_pkg::LAST_CELL));
        send_item(tcw_pkg::OP_READ, 8'hFF, 4'hF, 11'(tcw_pkg::CELL_COUNT));
        send_item(tcw_pkg::OP_READ, 8'h00, 4'h0, 11'h7FF);
        send_item(OP_UNUSED, 8'hFF, 4'hF, 11'h7FF);
        send_item(OP_UNUSED, 8'h00, 4'h0, 11'd0);
        // extreme characters with the reset attribute
        send_item(tcw_pkg::OP_PUT, 8'h00, 4'hF, 11'h7FF);
        send_item(tcw_pkg::OP_PUT, 8'hFF, 4'h0, 11'd0);
        send_item(tcw_pkg::OP_READ, 8'h00, 4'h0, 11'd0);
        send_item(tcw_pkg::OP_READ, 8'h00, 4'h0, 11'd1);
        send_item(tcw_pkg::OP_READ, 8'h00, 4'h0, 11'd2);
        send_item(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE, 4'h0, 11'd0);
        send_item(tcw_pkg::OP_PUT, 8'h5A, 4'h0, 11'd0);
        send_item(tcw_pkg::OP_READ, 8'h00, 4'h0, 11'(tcw_pkg::COLUMNS));
        // clear leaves the cursor alone
        send_item(tcw_pkg::OP_CLEAR, 8'hFF, 4'hF, 11'h7FF);
        send_item(tcw_pkg::OP_READ, 8'h00, 4'h0, 11'd0);
        send_item(tcw_pkg::OP_READ, 8'h00, 4'h0, 11'(tcw_pkg::LAST_CELL));
        send_item(tcw_pkg::OP_CLEAR, 8'h00, 4'h0, 11'd0);
        send_item(tcw_pkg::OP_READ, 8'h00, 4'h0, 11'(tcw_pkg::COLUMNS));
        send_item(tcw_pkg::OP_PUT, 8'h41, 4'h5, 11'd3);
        send_item(tcw_pkg::OP_READ, 8'h00, 4'h0, 11'(tcw_pkg::COLUMNS + 1));
        send_item(tcw_pkg::OP_READ, 8'h00, 4'h0, 11'(tcw_pkg::COLUMNS + 2));
    endtask

    task automatic test_traffic_phase(input int idle_pct, input int stall_pct,
                                      input tcw_pkg::color_t fg, input tcw_pkg::color_t bg,
                                      input int n_items);
        int sent;
        int pick;
        int run_len;
        int k;
        logic [7:0] ch;
        logic [10:0] idx;
        wait_for_results();
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        write_colors(fg, bg);
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
            begin
                send_item(tcw_pkg::OP_CLEAR, 8'($urandom), 4'($urandom), 11'($urandom));
                sent++;
            end
            else if (pick < 7)
            begin
                send_item(OP_UNUSED, 8'($urandom), 4'($urandom), 11'($urandom));
            end
            else if (pick < 10)
            begin
                wait_for_results();
            end
            else if (pick < 70)
            begin
                // a run of text; long runs cross the right edge
                run_len = ($urandom_range(9) == 0) ? $urandom_range(60, 120)
                                                   : $urandom_range(1, 30);
                repeat (run_len)
                begin
                    ch = ($urandom_range(99) < 8) ? tcw_pkg::NEWLINE_CODE : 8'($urandom);
                    send_item(tcw_pkg::OP_PUT, ch, 4'($urandom), 11'($urandom));
                end
                sent += run_len;
            end
            else
            begin
                run_len = $urandom_range(1, 4);
                repeat (run_len)
                begin
                    case ($urandom_range(3))
                        0:
                        begin
                            k = cur_row * tcw_pkg::COLUMNS + cur_col
                                - int'($urandom_range(0, 3));
                            if (k < 0)
                                k = 0;
                            if (k > tcw_pkg::CELL_COUNT - 1)
                                k = tcw_pkg::CELL_COUNT - 1;
                            idx = 11'(k);
                        end
                        1:
                        begin
                            idx = 11'((tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS
                                      + $urandom_range(tcw_pkg::COLUMNS - 1));
                        end
                        2:
                        begin
                            idx = 11'($urandom_range(tcw_pkg::CELL_COUNT - 1));
                        end
                        default:
                        begin
                            idx = 11'($urandom);
                        end
                    endcase
                    send_item(tcw_pkg::OP_READ, 8'($urandom), 4'($urandom), idx);
                end
                sent += run_len;
            end
        end
    endtask

    initial
    begin
        tcw_pkg::color_t fg;
        tcw_pkg::color_t bg;
        int idle_pct;
        int stall_pct;
        for (int i = 0; i < tcw_pkg::CELL_COUNT; i++)
            screen_copy[i] = '0;
        cur_col = 0;
        cur_row = 0;
        fg_color = tcw_pkg::TEXT_COLOR_RESET;
        bg_color = tcw_pkg::BACK_COLOR_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();

        for (int p = 0; p < TRAFFIC_PHASES; p++)
        begin
            case (p % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 63;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 63;
                end
                default:
                begin
                    idle_pct = 11;
                    stall_pct = 11;
                end
            endcase
            case (p)
                0:
                begin
                    fg = 4'h0;
                    bg = 4'h0;
                end
                1:
                begin
                    fg = 4'hF;
                    bg = 4'hF;
                end
                2:
                begin
                    fg = 4'h0;
                    bg = 4'hF;
                end
                3:
                begin
                    fg = 4'hF;
                    bg = 4'h0;
                end
                default:
                begin
                    fg = 4'($urandom);
                    bg = 4'($urandom);
                end
            endcase
            test_traffic_phase(idle_pct, stall_pct, fg, bg, PHASE_ITEMS);
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_status.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_status.size()));

        $display("covered %0d puts (%0d edge wraps, %0d scrolls), %0d clears,",
                 put_count, wrap_count, scroll_count, clear_count);
        $display("%0d reads (%0d off screen), %0d color settings, four idle/stall mixes,",
                 read_count, far_read_count, TRAFFIC_PHASES + 1);
        $display("%0d cycles, %0d mismatches", cycle_count, err_count);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
